### rtl/tkt_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tkt_pkg: shared constants and types for the top-k tracker
// Store depth, field widths and the controller-to-datapath command bundle.
// ----------------------------------------------------------------------------
package tkt_pkg;

    localparam int DEPTH       = 16;
    localparam int MAX_RESULTS = 16;
    localparam int VAL_W       = 32;
    localparam int CNT_W       = $clog2(DEPTH + 1);
    localparam int IDX_W       = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int FLD_W       = 5;   // capacity, want_count, held_count

    localparam logic OP_ADD  = 1'b0;
    localparam logic OP_READ = 1'b1;

    typedef struct packed {
        logic             add_en;    // apply s_tdata value to the store
        logic             out_load;  // load the output register
        logic             out_last;
        logic             out_none;  // empty-store marker
        logic [IDX_W-1:0] idx;       // store entry to send
    } tkt_cmd_t;

endpackage : tkt_pkg
`default_nettype wire

### rtl/tkt_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tkt_datapath: sorted store, insertion cells and output register
// One compare per entry; an add inserts, or replaces the minimum, at the edge that accepts it.
// ----------------------------------------------------------------------------
module tkt_datapath (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        cfg_wr_en,
    input  wire logic [tkt_pkg::FLD_W-1:0]   cfg_wr_data,
    input  wire logic signed [tkt_pkg::VAL_W-1:0] add_value,
    input  wire tkt_pkg::tkt_cmd_t           cmd,
    output logic [tkt_pkg::CNT_W-1:0]        count,
    output logic signed [tkt_pkg::VAL_W-1:0] out_value,
    output logic                             out_last,
    output logic                             out_none,
    output logic [tkt_pkg::FLD_W-1:0]        out_held
);
    import tkt_pkg::*;

    logic signed [VAL_W-1:0] store_reg [DEPTH];
    logic signed [VAL_W-1:0] store_next [DEPTH];
    logic [DEPTH:0]          le;          // entry valid and <= add_value
    logic [CNT_W-1:0]        count_reg, count_next;
    logic [FLD_W-1:0]        cap_reg;
    logic [CNT_W-1:0]        eff_cap;
    logic                    full, do_ins, do_rep;

    always_comb begin
        if (cap_reg == '0 || 32'(cap_reg) > 32'(DEPTH)) begin
            eff_cap = CNT_W'(DEPTH);
        end else begin
            eff_cap = CNT_W'(cap_reg);
        end
    end

    assign full   = (count_reg >= eff_cap);
    assign do_ins = cmd.add_en && !full;
    // replace only when strictly above the current minimum
    assign do_rep = cmd.add_en && full && (count_reg != '0) && (store_reg[0] < add_value);

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++) begin : g_cell
            assign le[gi] = (32'(count_reg) > gi) && (store_reg[gi] <= add_value);

            always_comb begin
                store_next[gi] = store_reg[gi];
                if (do_ins) begin
                    if (le[gi]) begin
                        store_next[gi] = store_reg[gi];
                    end else if (gi == 0) begin
                        store_next[gi] = add_value;
                    end else if (le[(gi > 0) ? gi - 1 : 0]) begin
                        store_next[gi] = add_value;
                    end else begin
                        store_next[gi] = store_reg[(gi > 0) ? gi - 1 : 0];
                    end
                end else if (do_rep) begin
                    if (le[gi + 1]) begin
                        store_next[gi] = store_reg[(gi + 1 < DEPTH) ? gi + 1 : gi];
                    end else if (gi == 0 || le[gi]) begin
                        store_next[gi] = add_value;
                    end else begin
                        store_next[gi] = store_reg[gi];
                    end
                end
            end

            always_ff @(posedge aclk) begin
                store_reg[gi] <= store_next[gi];
            end
        end
    endgenerate

    assign le[DEPTH] = 1'b0;

    assign count_next = do_ins ? count_reg + CNT_W'(1) : count_reg;
    assign count      = count_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            cap_reg   <= '0;
        end else begin
            count_reg <= count_next;
            if (cfg_wr_en) begin
                cap_reg <= cfg_wr_data;
            end
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_value <= cmd.out_none ? '0 : store_reg[cmd.idx];
            out_last  <= cmd.out_last;
            out_none  <= cmd.out_none;
            out_held  <= FLD_W'(count_reg);
        end
    end

    logic sorted_ok;
    always_comb begin
        sorted_ok = 1'b1;
        for (int i = 0; i + 1 < DEPTH; i++) begin
            if (32'(count_reg) > i + 1 && store_reg[i] > store_reg[i + 1]) begin
                sorted_ok = 1'b0;
            end
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(count_reg) <= 32'(DEPTH))
        else $error("held count above store depth");

    a_sorted: assert property (@(posedge aclk) disable iff (!aresetn)
        sorted_ok)
        else $error("store lost ascending order");

    a_no_grow_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.add_en && full) |=> (count_reg == $past(count_reg)))
        else $error("count changed on add to full store");

endmodule : tkt_datapath
`default_nettype wire

### rtl/tkt_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tkt_ctrl: item sequencer for the top-k tracker
// Accepts items, walks read runs one entry per transfer, owns m_tvalid.
// ----------------------------------------------------------------------------
module tkt_ctrl (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      s_tvalid,
    output logic                           s_tready,
    input  wire logic                      op,
    input  wire logic [tkt_pkg::FLD_W-1:0] want_count,
    input  wire logic                      ascending,
    output logic                           m_tvalid,
    input  wire logic                      m_tready,
    input  wire logic [tkt_pkg::CNT_W-1:0] count,
    output tkt_pkg::tkt_cmd_t              cmd
);
    import tkt_pkg::*;

    localparam logic ST_IDLE   = 1'b0;
    localparam logic ST_STREAM = 1'b1;

    logic             state_reg, state_next;
    logic [CNT_W-1:0] k_reg, k_next;
    logic [CNT_W-1:0] n_reg, n_next;
    logic             asc_reg, asc_next;
    logic             m_valid_reg, m_valid_next;
    logic             accept, slot_free, run_last;
    logic [CNT_W-1:0] n_calc, pos;

    assign s_tready  = (state_reg == ST_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign slot_free = !m_valid_reg || m_tready;
    assign m_tvalid  = m_valid_reg;

    always_comb begin
        if (want_count == '0 || 32'(want_count) > 32'(count)) begin
            n_calc = count;
        end else begin
            n_calc = CNT_W'(want_count);
        end
        if (32'(n_calc) > 32'(MAX_RESULTS)) begin
            n_calc = CNT_W'(MAX_RESULTS);
        end
    end

    assign pos      = asc_reg ? (count - n_reg + k_reg) : (count - CNT_W'(1) - k_reg);
    assign run_last = (count == '0) || (k_reg + CNT_W'(1) == n_reg);

    always_comb begin
        state_next   = state_reg;
        k_next       = k_reg;
        n_next       = n_reg;
        asc_next     = asc_reg;
        m_valid_next = m_valid_reg && !m_tready;
        cmd          = '0;
        cmd.idx      = IDX_W'(pos);
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (op == OP_ADD) begin
                        cmd.add_en = 1'b1;
                    end else begin
                        state_next = ST_STREAM;
                        k_next     = '0;
                        n_next     = n_calc;
                        asc_next   = ascending;
                    end
                end
            end
            ST_STREAM: begin
                if (slot_free) begin
                    cmd.out_load = 1'b1;
                    cmd.out_last = run_last;
                    cmd.out_none = (count == '0);
                    m_valid_next = 1'b1;
                    k_next       = k_reg + CNT_W'(1);
                    if (run_last) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            k_reg       <= '0;
            n_reg       <= '0;
            asc_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            k_reg       <= k_next;
            n_reg       <= n_next;
            asc_reg     <= asc_next;
            m_valid_reg <= m_valid_next;
        end
    end

    a_k_in_run: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_STREAM && count != '0) |-> (k_reg < n_reg))
        else $error("read index ran past run length");

    a_load_slot_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> slot_free)
        else $error("output register overwritten while held");

    a_count_still_in_run: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_STREAM && $past(state_reg) == ST_STREAM)
            |-> $stable(count))
        else $error("store changed during a read run");

endmodule : tkt_ctrl
`default_nettype wire

### rtl/top_k_largest_tracker_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// top_k_largest_tracker_unit: keeps the largest signed values seen so far
// Sorted store with per-entry insert cells; reads stream the top N values.
// ----------------------------------------------------------------------------
//  channel | dir | ports                          | contents
//  --------+-----+--------------------------------+------------------------------
//  input   | in  | s_tvalid s_tready s_tdata s_tuser | add / read items
//  result  | out | m_tvalid m_tready m_tdata m_tlast m_tuser | read values
//  config  | in  | cfg_wr_en cfg_wr_data          | capacity register
//
//  Sequencing: an add is applied in the accepting edge (insert or
//    replace-minimum done by the per-entry compare cells). A read is
//    accepted, then streams N results (or one marker) through the single
//    output register as m_tready frees it; the next item is taken after
//    the last result is loaded.
//  Reset: aresetn low clears held count, capacity (0 = full depth) and the
//    sequencer; store contents are not cleared and are only read below count.
//  Stalls: m_tready low holds the output register; s_tready is low while a
//    read run is streaming.
// ----------------------------------------------------------------------------
module top_k_largest_tracker_unit (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // config
    input  wire logic        cfg_wr_en,
    input  wire logic [4:0]  cfg_wr_data,  // capacity
    // input channel
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [39:0] s_tdata,      // [31:0] value_in, [36:32] want_count,
                                           // [37] ascending, [39:38] zero
    input  wire logic        s_tuser,      // [0] operation
    // result channel
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [39:0]      m_tdata,      // [31:0] value_out, [36:32] held_count,
                                           // [39:37] zero
    output logic             m_tlast,      // last
    output logic             m_tuser       // [0] none_held
);
    import tkt_pkg::*;

    tkt_cmd_t                cmd;
    logic [CNT_W-1:0]        count;
    logic signed [VAL_W-1:0] out_value;
    logic [FLD_W-1:0]        out_held;
    logic                    out_last, out_none;

    tkt_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .op         (s_tuser),
        .want_count (s_tdata[36:32]),
        .ascending  (s_tdata[37]),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .count      (count),
        .cmd        (cmd)
    );

    tkt_datapath u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .add_value   (s_tdata[31:0]),
        .cmd         (cmd),
        .count       (count),
        .out_value   (out_value),
        .out_last    (out_last),
        .out_none    (out_none),
        .out_held    (out_held)
    );

    // result transfer packing
    assign m_tdata = {3'b000, out_held, out_value};
    assign m_tlast = out_last;
    assign m_tuser = out_none;

endmodule : top_k_largest_tracker_unit
`default_nettype wire
